>>> hdl/tqc_pkg.sv
// Shared types and constants for the triangle quality checker.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package tqc_pkg;

  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_BITS_DEF      = 16;
  localparam int COSINE_FRAC_BITS_DEF = 14;

  // normalized vectors have their largest magnitude in [2^19, 2^20)
  localparam int NORM_TOP  = 20;
  localparam int ROOT_W    = NORM_TOP + 1;
  localparam int SQ_IN_W   = 2 * ROOT_W;

  localparam int N_CROSS   = 6;
  localparam int N_SQUARE  = 6;
  localparam int N_DOT     = 9;
  localparam int N_DEN     = 1;

  localparam int QUEUE_DEPTH = 2;

  localparam int REG_VERTEX_COUNT = 0;
  localparam int REG_AREA_FLOOR   = 1;
  localparam int REG_NORMAL_FLOOR = 2;
  localparam int PADDR_W          = 4;

  typedef enum logic [2:0] {
    VERDICT_OK           = 3'd0,
    VERDICT_BAD_INDEX    = 3'd1,
    VERDICT_REPEATED     = 3'd2,
    VERDICT_ZERO_AREA    = 3'd3,
    VERDICT_SHORT_NORMAL = 3'd4
  } verdict_e;

  typedef struct packed {
    logic        restart;
    logic [31:0] index_a;
    logic [31:0] index_b;
    logic [31:0] index_c;
    logic [47:0] pos_a;
    logic [47:0] pos_b;
    logic [47:0] pos_c;
    logic [47:0] normal_a;
    logic [47:0] normal_b;
    logic [47:0] normal_c;
  } in_item_t;

  typedef struct packed {
    verdict_e           verdict;
    logic signed [15:0] face_cosine;
    logic [31:0]        total_faces;
    logic [31:0]        cosine_faces;
    logic [31:0]        negative_faces;
    logic [31:0]        bad_index_faces;
    logic [31:0]        degenerate_faces;
    logic signed [15:0] min_cosine;
    logic signed [15:0] max_cosine;
    logic signed [47:0] cosine_sum;
  } out_item_t;

  typedef struct packed {
    logic [31:0] vertex_count;
    logic [31:0] area_floor;
    logic [31:0] normal_floor;
  } cfg_t;

  // classified request handed from the front to the back
  typedef struct packed {
    in_item_t item;
    logic     bad_index;
    logic     repeated;
  } entry_t;

endpackage

>>> hdl/tqc_front.sv
// Front end: classifies the index triple of an incoming request.
// Depends on tqc_pkg.
`timescale 1ns / 1ps
module tqc_front (
  input  tqc_pkg::in_item_t item_i,
  input  tqc_pkg::cfg_t     cfg_i,
  output tqc_pkg::entry_t   entry_o
);
  import tqc_pkg::*;

  logic bad, rep;

  always_comb begin
    bad = (item_i.index_a >= cfg_i.vertex_count) || (item_i.index_b >= cfg_i.vertex_count) ||
          (item_i.index_c >= cfg_i.vertex_count);
    rep = (item_i.index_a == item_i.index_b) || (item_i.index_b == item_i.index_c) ||
          (item_i.index_c == item_i.index_a);
    entry_o.item      = item_i;
    entry_o.bad_index = bad;
    entry_o.repeated  = rep;
  end

endmodule

>>> hdl/tqc_queue.sv
// Short queue between front and back end.
// Depends on tqc_pkg.
`timescale 1ns / 1ps
module tqc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  tqc_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output tqc_pkg::entry_t rdata_o,
  output logic            empty_o
);
  import tqc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wp_q, rp_q;
  logic [PTR_W:0]     cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i && !empty_o) rp_q <= (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PTR_W+1)'(wr_i && !full_o) - (PTR_W+1)'(rd_i && !empty_o);
    end
  end

endmodule

>>> hdl/tqc_core.sv
// Back end: sequencer with one shared multiplier, two bit-serial square roots,
// a shift-subtract divider, the running statistics and the result register.
// Depends on tqc_pkg.
`timescale 1ns / 1ps
module tqc_core #(
  parameter int COORD_BITS       = tqc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS      = tqc_pkg::NORMAL_BITS_DEF,
  parameter int COSINE_FRAC_BITS = tqc_pkg::COSINE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tqc_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  tqc_pkg::entry_t    q_entry_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output tqc_pkg::out_item_t out_item_o
);
  import tqc_pkg::*;

  localparam int E_W    = COORD_BITS + 1;
  localparam int CR_W   = 2 * E_W;
  localparam int NS_W   = NORMAL_BITS + 2;
  localparam int CRM_W  = (CR_W > ROOT_W) ? CR_W : ROOT_W;
  localparam int NSM_W  = NORM_TOP;
  localparam int MUL_W  = CRM_W + 1;
  localparam int P_W    = 2 * MUL_W;
  localparam int NSQ_W  = 2 * NS_W;
  localparam int D_W    = 2 * NORM_TOP + 3;
  localparam int DEN_W  = 2 * ROOT_W;
  localparam int Q_W    = COSINE_FRAC_BITS + 2;
  localparam int NUM_W  = DEN_W + Q_W;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CROSS = 11'b00000000010,
    S_CONV  = 11'b00000000100,
    S_SQ    = 11'b00000001000,
    S_CHECK = 11'b00000010000,
    S_NORM  = 11'b00000100000,
    S_DOT   = 11'b00001000000,
    S_SQRT  = 11'b00010000000,
    S_DEN   = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] k;

  logic                    restart_q;
  verdict_e                verdict_q;
  logic signed [E_W-1:0]   e1_q [3];
  logic signed [E_W-1:0]   e2_q [3];
  logic signed [NS_W-1:0]  ns_q [3];
  logic signed [CR_W-1:0]  cr_q [3];
  logic [CRM_W-1:0]        crm_q [3];
  logic                    crs_q [3];
  logic [NSM_W-1:0]        nsm_q [3];
  logic                    nss_q [3];
  logic                    big_q;
  logic [63:0]             csq_q;
  logic                    csq_sat_q;
  logic [NSQ_W-1:0]        nsq_q;
  logic signed [D_W-1:0]   d_q;
  logic [SQ_IN_W-1:0]      l2_q [2];
  logic [SQ_IN_W-1:0]      sx_q [2];
  logic [ROOT_W-1:0]       sr_q [2];
  logic [ROOT_W+1:0]       srem_q [2];
  logic [NUM_W-1:0]        rem_q, dsh_q;
  logic [Q_W-1:0]          quo_q;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [P_W-1:0]   prod_q;

  // running statistics
  logic                seen_q;
  logic signed [15:0]  low_q, high_q;
  logic signed [47:0]  sum_q;
  logic [31:0]         faces_q, valid_q, neg_q, badc_q, degc_q;

  out_item_t out_q;
  logic      out_valid_q;

  logic fin_go;
  assign k       = cnt_q - 1'b1;
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign fin_go  = (state_q == S_FIN) && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;
  assign out_item_o = out_q;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic [CR_W-1:0] crm_mag(input logic signed [CR_W-1:0] v);
    return v[CR_W-1] ? -v : v;
  endfunction

  // normalize tests
  logic cr_hi, cr_lo, ns_hi, ns_lo;
  always_comb begin
    cr_hi = 1'b0; cr_lo = 1'b1; ns_hi = 1'b0; ns_lo = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ((crm_q[i] >> NORM_TOP) != '0) cr_hi = 1'b1;
      if ((crm_q[i] >> (NORM_TOP - 1)) != '0) cr_lo = 1'b0;
      if (nsm_q[i][NSM_W-1]) ns_lo = 1'b0;
    end
  end

  // multiplier operand selection
  always_comb begin
    logic signed [MUL_W-1:0] tc, tn;
    logic [1:0] j;
    mul_a = '0;
    mul_b = '0;
    j = '0;
    tc = '0;
    tn = '0;
    unique case (state_q)
      S_CROSS: begin
        unique case (cnt_q)
          CNT_W'(0): begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
          CNT_W'(1): begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
          CNT_W'(2): begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
          CNT_W'(3): begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
          CNT_W'(4): begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
          CNT_W'(5): begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
          default: ;
        endcase
      end
      S_SQ: begin
        if (cnt_q < CNT_W'(3)) begin
          j = cnt_q[1:0];
          mul_a = MUL_W'({1'b0, crm_q[j]});
        end else if (cnt_q < CNT_W'(N_SQUARE)) begin
          j = 2'(cnt_q - CNT_W'(3));
          mul_a = MUL_W'({1'b0, nsm_q[j]});
        end
        mul_b = mul_a;
      end
      S_DOT: begin
        if (cnt_q < CNT_W'(3)) begin
          j  = cnt_q[1:0];
          tc = MUL_W'({1'b0, crm_q[j]});
          tn = MUL_W'({1'b0, nsm_q[j]});
          mul_a = crs_q[j] ? -tc : tc;
          mul_b = nss_q[j] ? -tn : tn;
        end else if (cnt_q < CNT_W'(6)) begin
          j = 2'(cnt_q - CNT_W'(3));
          mul_a = MUL_W'({1'b0, crm_q[j]});
          mul_b = mul_a;
        end else if (cnt_q < CNT_W'(N_DOT)) begin
          j = 2'(cnt_q - CNT_W'(6));
          mul_a = MUL_W'({1'b0, nsm_q[j]});
          mul_b = mul_a;
        end
      end
      S_DEN: begin
        mul_a = MUL_W'({1'b0, sr_q[0]});
        mul_b = MUL_W'({1'b0, sr_q[1]});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) prod_q <= P_W'(mul_a) * P_W'(mul_b);

  // next state
  always_comb begin
    logic [63:0] csq_eff;
    csq_eff = (big_q || csq_sat_q) ? 64'hFFFF_FFFF_FFFF_FFFF : csq_q;
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (!q_empty_i) begin
        state_d = (q_entry_i.bad_index || q_entry_i.repeated) ? S_FIN : S_CROSS;
      end
      S_CROSS: if (cnt_q == CNT_W'(N_CROSS)) state_d = S_CONV;
      S_CONV:  state_d = S_SQ;
      S_SQ:    if (cnt_q == CNT_W'(N_SQUARE)) state_d = S_CHECK;
      S_CHECK: begin
        if (csq_eff <= {32'd0, cfg_i.area_floor}) state_d = S_FIN;
        else if (nsq_q <= NSQ_W'(cfg_i.normal_floor) && (NSQ_W >= 32 ||
                 cfg_i.normal_floor >= 32'(nsq_q))) state_d = S_FIN;
        else state_d = S_NORM;
      end
      S_NORM:  if (!cr_hi && !cr_lo && !ns_lo) state_d = S_DOT;
      S_DOT:   if (cnt_q == CNT_W'(N_DOT)) state_d = S_SQRT;
      S_SQRT:  if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = S_DEN;
      S_DEN:   if (cnt_q == CNT_W'(N_DEN)) state_d = S_DIV;
      S_DIV:   if (cnt_q == CNT_W'(Q_W - 1)) state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic [SQ_IN_W-1:0] dmag;
    logic [DEN_W-1:0]   den;
    logic [64:0]        csum;
    logic [ROOT_W+1:0]  rsh, trial;
    logic               big;
    unique case (state_q)
      S_IDLE: begin
        restart_q <= q_entry_i.item.restart;
        verdict_q <= q_entry_i.bad_index ? VERDICT_BAD_INDEX :
                     q_entry_i.repeated  ? VERDICT_REPEATED  : VERDICT_OK;
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= E_W'($signed(q_entry_i.item.pos_b[16*i +: COORD_BITS])) -
                     E_W'($signed(q_entry_i.item.pos_a[16*i +: COORD_BITS]));
          e2_q[i] <= E_W'($signed(q_entry_i.item.pos_c[16*i +: COORD_BITS])) -
                     E_W'($signed(q_entry_i.item.pos_a[16*i +: COORD_BITS]));
          ns_q[i] <= NS_W'($signed(q_entry_i.item.normal_a[16*i +: NORMAL_BITS])) +
                     NS_W'($signed(q_entry_i.item.normal_b[16*i +: NORMAL_BITS])) +
                     NS_W'($signed(q_entry_i.item.normal_c[16*i +: NORMAL_BITS]));
        end
      end
      S_CROSS: if (cnt_q != '0) begin
        if (!k[0]) cr_q[k[2:1]] <= prod_q[CR_W-1:0];
        else       cr_q[k[2:1]] <= cr_q[k[2:1]] - prod_q[CR_W-1:0];
      end
      S_CONV: begin
        big        = 1'b0;
        csq_q     <= '0;
        csq_sat_q <= 1'b0;
        nsq_q     <= '0;
        for (int i = 0; i < 3; i++) begin
          crs_q[i] <= cr_q[i][CR_W-1];
          crm_q[i] <= CRM_W'(cr_q[i][CR_W-1] ? -cr_q[i] : cr_q[i]);
          nss_q[i] <= ns_q[i][NS_W-1];
          nsm_q[i] <= NSM_W'(ns_q[i][NS_W-1] ? -ns_q[i] : ns_q[i]);
          if ((64'(crm_mag(cr_q[i])) >> 32) != '0) big = 1'b1;
        end
        big_q <= big;
      end
      S_SQ: if (cnt_q != '0) begin
        if (k < CNT_W'(3)) begin
          csum = {1'b0, csq_q} + 65'($unsigned(prod_q));
          csq_q <= csum[63:0];
          if (csum[64]) csq_sat_q <= 1'b1;
        end else begin
          nsq_q <= nsq_q + NSQ_W'($unsigned(prod_q));
        end
      end
      S_CHECK: begin
        if ((big_q || csq_sat_q ? 64'hFFFF_FFFF_FFFF_FFFF : csq_q) <= {32'd0, cfg_i.area_floor})
          verdict_q <= VERDICT_ZERO_AREA;
        else if (64'(nsq_q) <= {32'd0, cfg_i.normal_floor})
          verdict_q <= VERDICT_SHORT_NORMAL;
        d_q     <= '0;
        l2_q[0] <= '0;
        l2_q[1] <= '0;
      end
      S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (cr_hi)      crm_q[i] <= crm_q[i] >> 1;
          else if (cr_lo) crm_q[i] <= crm_q[i] << 1;
          if (ns_lo)      nsm_q[i] <= nsm_q[i] << 1;
        end
      end
      S_DOT: begin
        if (cnt_q != '0) begin
          if (k < CNT_W'(3))      d_q     <= d_q + D_W'(prod_q);
          else if (k < CNT_W'(6)) l2_q[0] <= l2_q[0] + SQ_IN_W'($unsigned(prod_q));
          else                    l2_q[1] <= l2_q[1] + SQ_IN_W'($unsigned(prod_q));
        end
        for (int u = 0; u < 2; u++) begin
          sr_q[u]   <= '0;
          srem_q[u] <= '0;
        end
        sx_q[0] <= l2_q[0];
        sx_q[1] <= (cnt_q == CNT_W'(N_DOT)) ? l2_q[1] + SQ_IN_W'($unsigned(prod_q)) : l2_q[1];
      end
      S_SQRT: begin
        for (int u = 0; u < 2; u++) begin
          rsh   = {srem_q[u][ROOT_W-1:0], sx_q[u][SQ_IN_W-1 -: 2]};
          trial = {sr_q[u], 2'b01};
          sx_q[u] <= {sx_q[u][SQ_IN_W-3:0], 2'b00};
          if (rsh >= trial) begin
            srem_q[u] <= rsh - trial;
            sr_q[u]   <= {sr_q[u][ROOT_W-2:0], 1'b1};
          end else begin
            srem_q[u] <= rsh;
            sr_q[u]   <= {sr_q[u][ROOT_W-2:0], 1'b0};
          end
        end
      end
      S_DEN: if (cnt_q != '0) begin
        den  = prod_q[DEN_W-1:0];
        dmag = SQ_IN_W'(d_q[D_W-1] ? -d_q : d_q);
        rem_q <= (NUM_W'(dmag) << COSINE_FRAC_BITS) + NUM_W'(den >> 1);
        dsh_q <= NUM_W'(den) << (Q_W - 1);
        quo_q <= '0;
      end
      S_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[Q_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[Q_W-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      default: ;
    endcase
  end

  // statistics and result register
  logic signed [15:0] cosv;
  logic [Q_W-1:0]     qc;
  always_comb begin
    qc   = (quo_q > Q_W'(1 << COSINE_FRAC_BITS)) ? Q_W'(1 << COSINE_FRAC_BITS) : quo_q;
    cosv = d_q[D_W-1] ? -16'(qc) : 16'(qc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic                b_seen;
    logic signed [15:0]  b_low, b_high, c;
    logic signed [47:0]  b_sum;
    logic signed [48:0]  s49;
    logic [31:0]         b_faces, b_valid, b_neg, b_bad, b_deg;
    if (!rst_ni) begin
      seen_q <= 1'b0; low_q <= '0; high_q <= '0; sum_q <= '0;
      faces_q <= '0; valid_q <= '0; neg_q <= '0; badc_q <= '0; degc_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else if (fin_go) begin
      b_seen  = restart_q ? 1'b0 : seen_q;
      b_low   = restart_q ? '0 : low_q;
      b_high  = restart_q ? '0 : high_q;
      b_sum   = restart_q ? '0 : sum_q;
      b_faces = restart_q ? '0 : faces_q;
      b_valid = restart_q ? '0 : valid_q;
      b_neg   = restart_q ? '0 : neg_q;
      b_bad   = restart_q ? '0 : badc_q;
      b_deg   = restart_q ? '0 : degc_q;
      c       = '0;
      b_faces = sat_inc(b_faces);
      case (verdict_q) inside
        VERDICT_BAD_INDEX: b_bad = sat_inc(b_bad);
        VERDICT_REPEATED, VERDICT_ZERO_AREA: b_deg = sat_inc(b_deg);
        VERDICT_OK: begin
          c = cosv;
          b_valid = sat_inc(b_valid);
          if (c < 0) b_neg = sat_inc(b_neg);
          if (!b_seen) begin
            b_low = c; b_high = c; b_seen = 1'b1;
          end else begin
            if (c < b_low)  b_low  = c;
            if (c > b_high) b_high = c;
          end
          s49 = 49'(b_sum) + 49'(c);
          if (s49[48] != s49[47]) b_sum = s49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          else b_sum = s49[47:0];
        end
        default: ;
      endcase
      seen_q <= b_seen; low_q <= b_low; high_q <= b_high; sum_q <= b_sum;
      faces_q <= b_faces; valid_q <= b_valid; neg_q <= b_neg; badc_q <= b_bad; degc_q <= b_deg;
      out_valid_q <= 1'b1;
      out_q.verdict          <= verdict_q;
      out_q.face_cosine      <= c;
      out_q.total_faces      <= b_faces;
      out_q.cosine_faces     <= b_valid;
      out_q.negative_faces   <= b_neg;
      out_q.bad_index_faces  <= b_bad;
      out_q.degenerate_faces <= b_deg;
      out_q.min_cosine       <= b_low;
      out_q.max_cosine       <= b_high;
      out_q.cosine_sum       <= b_sum;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

>>> hdl/triangle_quality_checker.sv
// Top level of the triangle quality checker: register port, front end,
// request queue and back end. Depends on tqc_pkg, tqc_front, tqc_queue, tqc_core.
//
// Usage: triangles enter through a queue-style port (push/full); results leave
// through a queue-style port (empty/pop), one result per triangle, in order.
// Three 32-bit registers (vertex_count at 0x0, area_floor at 0x4, normal_floor
// at 0x8) are written over the APB-style port; pready is always high.
// The front classifies indices as a triangle is pushed and parks it in a
// two-entry queue. The back works on one triangle at a time:
// bad or repeated indices go straight to the result register; other faces run
// six cross products and six squares on one shared multiplier (after which
// faces that fail the area or normal floor leave), the normalizing shifter
// (one bit a cycle), nine more products, two parallel 21-step square roots,
// one product and a 16-step divider.
// Reset clears registers, statistics, queue and result register. When pop is
// held low the finished result holds on the port, the back waits with the next
// result ready, and the queue fills until full rises.
`timescale 1ns / 1ps
module triangle_quality_checker #(
  parameter int COORD_BITS       = tqc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_BITS      = tqc_pkg::NORMAL_BITS_DEF,
  parameter int COSINE_FRAC_BITS = tqc_pkg::COSINE_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  tqc_pkg::in_item_t            in_item_i,
  output logic                         empty,
  input  logic                         pop,
  output tqc_pkg::out_item_t           out_item_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tqc_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import tqc_pkg::*;

  cfg_t   cfg_q;
  entry_t f_entry, q_entry;
  logic   q_empty, q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[PADDR_W-1:2])
        2'(REG_VERTEX_COUNT): cfg_q.vertex_count <= pwdata;
        2'(REG_AREA_FLOOR):   cfg_q.area_floor   <= pwdata;
        2'(REG_NORMAL_FLOOR): cfg_q.normal_floor <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      2'(REG_VERTEX_COUNT): prdata = cfg_q.vertex_count;
      2'(REG_AREA_FLOOR):   prdata = cfg_q.area_floor;
      2'(REG_NORMAL_FLOOR): prdata = cfg_q.normal_floor;
      default:              prdata = '0;
    endcase
  end

  tqc_front u_front (
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .entry_o (f_entry)
  );

  tqc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (f_entry),
    .full_o  (full),
    .rd_i    (q_pop),
    .rdata_o (q_entry),
    .empty_o (q_empty)
  );

  tqc_core #(
    .COORD_BITS       (COORD_BITS),
    .NORMAL_BITS      (NORMAL_BITS),
    .COSINE_FRAC_BITS (COSINE_FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule
